>>> hdl/edu_pkg.sv
// Shared types and constants for the Euclidean distance unit.
package edu_pkg;

  localparam int SUM_W      = 38;
  localparam int DIST_W     = 19;
  localparam int SQ_IN_W    = 19;
  localparam int ROOT_STEPS = 19;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIFF   = 5'b00010,
    ST_SQUARE = 5'b00100,
    ST_ACCUM  = 5'b01000,
    ST_ROOT   = 5'b10000
  } edu_state_t;

endpackage

>>> hdl/edu_isqrt.sv
// Iterative integer square root: one compare-and-subtract step per cycle.
module edu_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [edu_pkg::SUM_W-1:0]   operand,
  output logic                        done,
  output logic [edu_pkg::DIST_W-1:0]  root
);

  logic [edu_pkg::SUM_W-1:0]  rem;
  logic [edu_pkg::SUM_W-1:0]  res;
  logic [edu_pkg::SUM_W-1:0]  bitpos;
  logic [edu_pkg::STEP_W-1:0] step;
  logic                       busy;
  logic [edu_pkg::SUM_W-1:0]  trial;
  logic                       fits;

  assign trial = res + bitpos;
  assign fits  = rem >= trial;
  assign root  = res[edu_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= edu_pkg::STEP_W'(edu_pkg::ROOT_STEPS - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= operand;
      res    <= '0;
      bitpos <= edu_pkg::SUM_W'(1) << (edu_pkg::SUM_W - 2);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitpos;
      end else begin
        res <= res >> 1;
      end
      bitpos <= bitpos >> 2;
    end
  end

endmodule

>>> hdl/euclidean_distance_unit_top.sv
// Euclidean distance unit: sequencer, multiply-accumulate and result register.
// An item without the last flag takes the steps difference, square, accumulate.
// An item with the last flag adds the 19 steps of the square root unit;
// out_valid rises once the result register is free, and in_ready returns then.
// The finished distance waits in its own register, so the next vector proceeds.
// Synchronous active-high reset clears the running sum and all handshake state.
module euclidean_distance_unit_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COORD_WIDTH-1:0] coord_first,
  input  logic signed [COORD_WIDTH-1:0] coord_second,
  input  logic                        last_element,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [edu_pkg::DIST_W-1:0]  distance
);

  // The difference needs one bit more than the coordinates; the magnitude is
  // then widened so that the test for an oversized difference is uniform.
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int MAG_W  = (DIFF_W > edu_pkg::SQ_IN_W + 1) ? DIFF_W : edu_pkg::SQ_IN_W + 1;

  edu_pkg::edu_state_t state, state_next;

  // Operands of the beat under work.
  logic signed [COORD_WIDTH-1:0] a_q;
  logic signed [COORD_WIDTH-1:0] b_q;
  logic                          last_q;

  // Datapath registers between the sequencer steps.
  logic [edu_pkg::SQ_IN_W-1:0] mag;
  logic                        huge;
  logic [edu_pkg::SUM_W-1:0]   square;
  logic [edu_pkg::SUM_W-1:0]   square_sum;

  logic signed [DIFF_W-1:0]   diff;
  logic [MAG_W-1:0]           mag_wide;
  logic [edu_pkg::SUM_W:0]    acc_raw;
  logic [edu_pkg::SUM_W-1:0]  acc_sum;

  logic                        root_start;
  logic                        root_done;
  logic [edu_pkg::DIST_W-1:0]  root;

  // Set once the root unit reports done, until the result is moved out.
  logic root_pending;

  assign in_ready = (state == edu_pkg::ST_IDLE);

  // Difference and its magnitude, sign-extended to a common width.
  assign diff     = DIFF_W'(a_q) - DIFF_W'(b_q);
  assign mag_wide = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  // Saturating accumulate: a carry out of the sum pins it at the maximum.
  assign acc_raw = {1'b0, square_sum} + {1'b0, square};
  assign acc_sum = acc_raw[edu_pkg::SUM_W] ? edu_pkg::SUM_MAX
                                           : acc_raw[edu_pkg::SUM_W-1:0];

  // The root starts on the final sum while the running sum is cleared.
  assign root_start = (state == edu_pkg::ST_ACCUM) && last_q;

  edu_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (acc_sum),
    .done    (root_done),
    .root    (root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      edu_pkg::ST_IDLE: begin
        if (in_valid) state_next = edu_pkg::ST_DIFF;
      end
      edu_pkg::ST_DIFF:   state_next = edu_pkg::ST_SQUARE;
      edu_pkg::ST_SQUARE: state_next = edu_pkg::ST_ACCUM;
      edu_pkg::ST_ACCUM: begin
        state_next = last_q ? edu_pkg::ST_ROOT : edu_pkg::ST_IDLE;
      end
      edu_pkg::ST_ROOT: begin
        // The root stays in the unit until the result register is free.
        if (root_done) state_next = edu_pkg::ST_ROOT;
        if (root_pending && (!out_valid || out_ready)) state_next = edu_pkg::ST_IDLE;
      end
      default: state_next = edu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= edu_pkg::ST_IDLE;
      square_sum   <= '0;
      out_valid    <= 1'b0;
      root_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (state == edu_pkg::ST_ACCUM) begin
        square_sum <= last_q ? '0 : acc_sum;
      end
      if (root_done) begin
        root_pending <= 1'b1;
      end
      if (state == edu_pkg::ST_ROOT && root_pending && (!out_valid || out_ready)) begin
        out_valid    <= 1'b1;
        root_pending <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_q    <= coord_first;
      b_q    <= coord_second;
      last_q <= last_element;
    end
    if (state == edu_pkg::ST_DIFF) begin
      mag  <= mag_wide[edu_pkg::SQ_IN_W-1:0];
      huge <= (mag_wide >> edu_pkg::SQ_IN_W) != '0;
    end
    if (state == edu_pkg::ST_SQUARE) begin
      square <= huge ? edu_pkg::SUM_MAX
                     : edu_pkg::SUM_W'(mag) * edu_pkg::SUM_W'(mag);
    end
    if (state == edu_pkg::ST_ROOT && root_pending && (!out_valid || out_ready)) begin
      distance <= root;
    end
  end

endmodule

>>> dv/euclidean_distance_unit_top_test.sv
// Self-checking testbench for the Euclidean distance unit: directed vectors, then random ones.
`timescale 1ns / 100ps

module euclidean_distance_unit_top_test;

  // The block runs at its default coordinate width. The coordinate type below follows from it.
  localparam int COORD_W = 16;
  localparam int DST_W   = edu_pkg::DIST_W;

  // The running sum saturates at its all-ones value. A difference this large or more
  // counts as saturated. That cannot happen at 16 bits but costs nothing to model.
  localparam longint SUM_LIMIT = (longint'(1) << edu_pkg::SUM_W) - 1;
  localparam longint HUGE_DIFF = longint'(1) << edu_pkg::DIST_W;

  localparam int RANDOM_ITEMS = 640;

  // The slowest correct run per item is the block latency plus the longest sender gap
  // and the longest receiver stall. About 850 items go in.
  // The limit leaves a wide margin above that.
  localparam int CYCLE_LIMIT = 600000;

  // The final wait is longer than the time from a beat to its result.
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [COORD_W-1:0] coord_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  coord_t               coord_first;
  coord_t               coord_second;
  logic                 last_element;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DST_W-1:0]     distance;

  // This is the reference state. It holds the sum of squared differences of the vector
  // in flight and the distances that are still due from the block, oldest first.
  longint               vector_sq_sum;
  logic [DST_W-1:0]     expected_dist_q[$];
  logic [DST_W-1:0]     due_dist;

  int                   error_count = 0;
  int                   cycle_count = 0;
  int                   items_sent;
  int                   rx_stall = 0;
  bit                   sender_gaps;

  euclidean_distance_unit_top #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .coord_first (coord_first),
    .coord_second(coord_second),
    .last_element(last_element),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .distance    (distance)
  );

  always #6 clk = ~clk;

  // This is the watchdog. A hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d distances still due", $time, expected_dist_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle lengths are mostly zero or short. About one in twelve is long, so that stalls
  // can cover the whole square root pass and beyond.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // This computes the integer square root, rounded down. Each result bit is tried from
  // the top down and is kept when the trial value squared still fits under the sum.
  function automatic logic [DST_W-1:0] floor_root(input longint n);
    longint root;
    longint trial;
    root = 0;
    for (int i = DST_W - 1; i >= 0; i--) begin
      trial = root | (longint'(1) << i);
      if (trial * trial <= n) root = trial;
    end
    return root[DST_W-1:0];
  endfunction

  // This folds one accepted coordinate pair into the reference sum. When the pair closes
  // the vector, the distance becomes due and the sum restarts from zero.
  task automatic add_coord_pair(input coord_t a, input coord_t b, input logic last);
    longint diff;
    longint mag;
    longint sq;
    diff = longint'(a) - longint'(b);
    mag  = (diff < 0) ? -diff : diff;
    sq   = (mag >= HUGE_DIFF) ? SUM_LIMIT : mag * mag;
    if (sq > SUM_LIMIT - vector_sq_sum) vector_sq_sum = SUM_LIMIT;
    else vector_sq_sum = vector_sq_sum + sq;
    if (last) begin
      expected_dist_q.insert(expected_dist_q.size(), floor_root(vector_sq_sum));
      vector_sq_sum = 0;
    end
  endtask

  // This sends one beat. Valid is left high on return, so that a following beat with no
  // gap keeps it high without a drop. Valid is lowered only when a gap is taken. The
  // prediction is made at the edge that accepts the beat.
  task automatic send_pair(input coord_t a, input coord_t b, input logic last);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    coord_first  <= a;
    coord_second <= b;
    last_element <= last;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    add_coord_pair(a, b, last);
    items_sent++;
  endtask

  // This is the sender's pause. It lowers valid and waits until every due distance has
  // arrived, so that the block goes fully idle between two bursts.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_dist_q.size() != 0) @(posedge clk);
  endtask

  // Coordinates come mostly from the full range, so that every bit is seen at both values.
  // The two extremes and a band of small values around zero are chosen on purpose.
  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return coord_t'($urandom_range(16)) - coord_t'(8);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // This is the receiver and the checker in one process. A beat is checked against the
  // oldest due distance at the edge that takes it. Stalls are started at random, except
  // while bits 9 and 8 of the cycle count are both set, when no new stall is started.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_dist_q.size() == 0) begin
        $display("%0t: distance beat with none due, expected none, actual %0d",
                 $time, distance);
        error_count++;
      end else begin
        due_dist = expected_dist_q.pop_front();
        if (distance !== due_dist) begin
          $display("%0t: distance mismatch, expected %0d, actual %0d",
                   $time, due_dist, distance);
          error_count++;
        end
      end
    end
    if (rx_stall > 0) begin
      rx_stall  <= rx_stall - 1;
      out_ready <= 1'b0;
    end else if (cycle_count[9:8] != 2'b11 && $urandom_range(3) == 0) begin
      rx_stall  <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // A vector of one element, sent as the very first beat after reset. Two more follow
  // right after a result. Each of them must still count its own square.
  task automatic test_single_element_vectors();
    sender_gaps = 1'b0;
    send_pair(16'sd100, -16'sd100, 1'b1);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    sender_gaps = 1'b1;
  endtask

  // This covers the field extremes, differences of one in both orders, exact roots and
  // inexact roots. A single 65535 difference must come back unchanged.
  task automatic test_field_extremes();
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7FFF, 16'sh8000, 1'b1);
    send_pair(16'sd0, -16'sd1, 1'b0);
    send_pair(-16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(16'sd3, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd4, 1'b1);
    send_pair(16'sd3, 16'sd0, 1'b0);
    send_pair(16'sd4, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b1);
    send_pair(16'sh5555, -16'sh2AAB, 1'b0);
    send_pair(-16'sh5556, 16'sh2AAA, 1'b0);
    send_pair(16'sh0F0F, 16'sh70F0, 1'b1);
  endtask

  // With 64 maximal differences the sum stays just under its limit, and the root is
  // exactly 8 * 65535. With 66 the sum saturates and the distance is the top value. A
  // short vector afterward shows that the saturated sum was cleared.
  task automatic test_sum_saturation();
    for (int i = 0; i < 64; i++) send_pair(16'sh7FFF, 16'sh8000, i == 63);
    for (int i = 0; i < 66; i++) send_pair(16'sh8000, 16'sh7FFF, i == 65);
    send_pair(16'sd3, -16'sd1, 1'b1);
  endtask

  // Single-element vectors are sent back to back while the receiver stalls at random. Then
  // the sender pauses until the block has drained, and sends again from idle.
  task automatic test_pause_until_drained();
    sender_gaps = 1'b0;
    for (int i = 0; i < 6; i++) send_pair(pick_coord(), pick_coord(), 1'b1);
    sender_gaps = 1'b1;
    for (int i = 0; i < 4; i++) send_pair(pick_coord(), pick_coord(), i == 3);
    wait_all_results();
    send_pair(pick_coord(), pick_coord(), 1'b0);
    send_pair(pick_coord(), pick_coord(), 1'b1);
  endtask

  // This sends random vectors. Most are one to eight elements long and some are medium.
  // A few have 60 to 80 near-maximal differences, so that they can cross into saturation.
  // Gaps on the sender are switched off for about a quarter of the vectors.
  task automatic test_random_vectors();
    int     start_items;
    int     len;
    int     r;
    int     off;
    coord_t a;
    coord_t b;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 80) len = $urandom_range(1, 8);
      else if (r < 96) len = $urandom_range(9, 40);
      else len = $urandom_range(60, 80);
      sender_gaps = ($urandom_range(3) != 0);
      for (int i = 0; i < len; i++) begin
        if (len >= 60) begin
          off = $urandom_range(255);
          a   = coord_t'(16'sh7FFF - off);
          b   = coord_t'(16'sh8000 + off);
          if ($urandom_range(1)) send_pair(b, a, i == len - 1);
          else send_pair(a, b, i == len - 1);
        end else begin
          send_pair(pick_coord(), pick_coord(), i == len - 1);
        end
      end
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    coord_first   = '0;
    coord_second  = '0;
    last_element  = 1'b0;
    vector_sq_sum = 0;
    items_sent    = 0;
    sender_gaps   = 1'b1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_single_element_vectors();
    test_field_extremes();
    test_sum_saturation();
    test_pause_until_drained();
    test_random_vectors();

    // Every due distance must arrive. The extra cycles then catch any stray result.
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/edu_pkg.sv
hdl/edu_isqrt.sv
hdl/euclidean_distance_unit_top.sv
dv/euclidean_distance_unit_top_test.sv
